/* hw/rtl/ibvs_velocity_law_2x2_defines.svh */
// Assertion macros for the visual servo velocity law block.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef IBVS_VELOCITY_LAW_2X2_DEFINES_SVH
`define IBVS_VELOCITY_LAW_2X2_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every clk edge outside reset
`define IVL_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ibvs velocity law check failed");

// Next-cycle implication
`define IVL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ibvs velocity law check failed");

`else

`define IVL_ASSERT_IMPLIES(lbl, ante, cons)
`define IVL_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* hw/rtl/ivl_pkg.sv */
// Shared types, constants and helpers for the visual servo velocity law.
// No dependencies; imported by every module of the block.
package ivl_pkg;

	localparam int WORD_W    = 32;
	localparam int GAIN_W    = 31;
	localparam int CFG_IDX_W = 1;
	localparam int PROD_W    = 64;
	localparam int WIDE_W    = 65;
	localparam int SAT_W     = 50;
	localparam int DIFF_W    = 33;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SERVO_GAIN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FF_ENABLE  = 1'd1;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 31'd65536;

	// Multiply schedule: one product per step, consumed one step later
	localparam int MUL_SEL_W = 3;
	typedef logic [MUL_SEL_W-1:0] mul_sel_t;
	localparam mul_sel_t MUL_GE0 = 3'd0;  // gain * error_0
	localparam mul_sel_t MUL_GE1 = 3'd1;  // gain * error_1
	localparam mul_sel_t MUL_D0  = 3'd2;  // jac_00 * jac_11
	localparam mul_sel_t MUL_D1  = 3'd3;  // jac_01 * jac_10
	localparam mul_sel_t MUL_N00 = 3'd4;  // jac_11 * u_0
	localparam mul_sel_t MUL_N01 = 3'd5;  // jac_01 * u_1
	localparam mul_sel_t MUL_N10 = 3'd6;  // jac_00 * u_1
	localparam mul_sel_t MUL_N11 = 3'd7;  // jac_10 * u_0

	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_LAST = 4'd8;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef logic signed [DIFF_W-1:0] diff_t;

	// Controller to datapath commands
	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     acc_en;
		mul_sel_t acc_sel;
		logic     div_start;
		logic     div_sel;
		logic     vel_we;
		logic     out_load;
	} ivl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic div_done;
		logic det_zero;
	} ivl_status_t;

	// Clamp a signed value to the 32-bit range
	function automatic word_t sat32(input logic signed [SAT_W-1:0] v);
		logic [SAT_W-WORD_W:0] hi;
		word_t r;
		hi = v[SAT_W-1:WORD_W-1];
		if ((&hi) || !(|hi)) begin
			r = v[WORD_W-1:0];
		end else if (v[SAT_W-1]) begin
			r = {1'b1, {(WORD_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(WORD_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

/* hw/rtl/ivl_div.sv */
// Bit-serial divider: sat32(round(num * 2^16 / den)), half away from zero.
// Depends on ivl_pkg; one quotient bit per cycle, den must be nonzero.
module ivl_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  ivl_pkg::wide_t num,
	input  ivl_pkg::wide_t den,
	output logic           done,
	output ivl_pkg::word_t quo
);
	import ivl_pkg::*;

	localparam int MAG_W     = 64;
	localparam int QUO_W     = 33;
	localparam int FRAC_W    = 16;
	localparam int DIV_STEPS = QUO_W;
	localparam int CNT_W     = 6;
	localparam int RMAG_W    = QUO_W + 1;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_CHECK = 2'd1;
	localparam logic [1:0] PH_ITER  = 2'd2;
	localparam logic [1:0] PH_ROUND = 2'd3;

	logic [1:0]        ph_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [MAG_W-1:0]  mn_q;
	logic [MAG_W-1:0]  md_q;
	logic              neg_q;
	logic              sat_q;
	logic [MAG_W-1:0]  r_q;
	logic [QUO_W-1:0]  sh_q;
	logic [QUO_W-1:0]  q_q;
	word_t             quo_q;

	logic [WIDE_W-1:0] num_abs;
	logic [WIDE_W-1:0] den_abs;
	logic [MAG_W:0]    trial;
	logic [MAG_W+1:0]  trial_diff;
	logic              trial_ge;
	logic [RMAG_W-1:0] rmag;
	word_t             quo_next;

	// Magnitudes of the operands
	assign num_abs = num[WIDE_W-1] ? WIDE_W'(-num) : WIDE_W'(num);
	assign den_abs = den[WIDE_W-1] ? WIDE_W'(-den) : WIDE_W'(den);

	// One restoring step
	assign trial      = {r_q, sh_q[QUO_W-1]};
	assign trial_diff = {1'b0, trial} - {2'b00, md_q};
	assign trial_ge   = !trial_diff[MAG_W+1];

	// Round the 17-fraction-bit quotient, then apply sign and clamp
	always_comb begin
		if (sat_q) begin
			rmag = {1'b0, 1'b1, {(QUO_W-1){1'b0}}};
		end else begin
			rmag = ({1'b0, q_q} + RMAG_W'(1)) >> 1;
		end
		if (neg_q) begin
			if (rmag > RMAG_W'({1'b1, {(WORD_W-1){1'b0}}})) begin
				quo_next = {1'b1, {(WORD_W-1){1'b0}}};
			end else begin
				quo_next = -rmag[WORD_W-1:0];
			end
		end else begin
			if (rmag > RMAG_W'({1'b0, {(WORD_W-1){1'b1}}})) begin
				quo_next = {1'b0, {(WORD_W-1){1'b1}}};
			end else begin
				quo_next = rmag[WORD_W-1:0];
			end
		end
	end

	// Sequence the division
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (ph_q == PH_ROUND);
			unique case (ph_q)
				PH_IDLE: begin
					if (start) begin
						ph_q <= PH_CHECK;
					end
				end
				PH_CHECK: begin
					cnt_q <= '0;
					ph_q  <= PH_ITER;
				end
				PH_ITER: begin
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						ph_q <= PH_ROUND;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				PH_ROUND: begin
					ph_q <= PH_IDLE;
				end
				default: begin
					ph_q <= PH_IDLE;
				end
			endcase
		end
	end

	// Working registers of the divider
	always_ff @(posedge clk) begin
		if (ph_q == PH_IDLE && start) begin
			mn_q  <= num_abs[MAG_W-1:0];
			md_q  <= den_abs[MAG_W-1:0];
			neg_q <= num[WIDE_W-1] ^ den[WIDE_W-1];
		end
		if (ph_q == PH_CHECK) begin
			// Quotient of 2^16 or more saturates at any sign
			sat_q <= {{FRAC_W{1'b0}}, mn_q} >= {md_q, {FRAC_W{1'b0}}};
			r_q   <= {{FRAC_W{1'b0}}, mn_q[MAG_W-1:FRAC_W]};
			sh_q  <= {mn_q[FRAC_W-1:0], {(QUO_W-FRAC_W){1'b0}}};
			q_q   <= '0;
		end
		if (ph_q == PH_ITER) begin
			r_q  <= trial_ge ? trial_diff[MAG_W-1:0] : trial[MAG_W-1:0];
			q_q  <= {q_q[QUO_W-2:0], trial_ge};
			sh_q <= {sh_q[QUO_W-2:0], 1'b0};
		end
		if (ph_q == PH_ROUND) begin
			quo_q <= quo_next;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* hw/rtl/ivl_datapath.sv */
// Datapath of the velocity law: input and config registers, shared multiplier,
// accumulators, divider and result register. Depends on ivl_pkg and ivl_div.
module ivl_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ivl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ivl_pkg::GAIN_W-1:0]     cfg_data,
	input  ivl_pkg::word_t                 feature_0,
	input  ivl_pkg::word_t                 feature_1,
	input  ivl_pkg::word_t                 target_0,
	input  ivl_pkg::word_t                 target_1,
	input  ivl_pkg::word_t                 jac_00,
	input  ivl_pkg::word_t                 jac_01,
	input  ivl_pkg::word_t                 jac_10,
	input  ivl_pkg::word_t                 jac_11,
	input  ivl_pkg::ivl_cmd_t              cmd,
	output ivl_pkg::ivl_status_t           status,
	output ivl_pkg::word_t                 velocity_0,
	output ivl_pkg::word_t                 velocity_1,
	output ivl_pkg::word_t                 error_0,
	output ivl_pkg::word_t                 error_1,
	output logic                           singular
);
	import ivl_pkg::*;

	localparam int MUL_OP_W   = WORD_W + 1;
	localparam int MUL_FULL_W = 2 * MUL_OP_W;
	localparam int Q_SHIFT    = 16;

	// Configuration and state
	logic [GAIN_W-1:0] gain_q;
	logic              ff_q;
	word_t             prev0_q;
	word_t             prev1_q;
	logic              first_q;

	// Item registers
	word_t j00_q, j01_q, j10_q, j11_q;
	word_t err0_q, err1_q;
	diff_t td0_q, td1_q;
	word_t u0_q, u1_q;
	prod_t prod_s1;
	wide_t hold_q, det_q, n0_q, n1_q;
	word_t vel0_q, vel1_q;

	// Result register
	word_t out_vel0_q, out_vel1_q, out_err0_q, out_err1_q;
	logic  out_sing_q;

	diff_t                        ediff0, ediff1, tdiff0, tdiff1;
	logic signed [MUL_OP_W-1:0]   mul_a, mul_b;
	logic signed [MUL_FULL_W-1:0] mul_full;
	wide_t                        rnd_sum;
	wide_t                        rnd_q16;
	diff_t                        td_sel;
	logic signed [SAT_W-1:0]      u_sum;
	wide_t                        diff_acc;
	logic                         det_zero;
	logic                         div_done;
	word_t                        div_quo;

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			ff_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SERVO_GAIN: gain_q <= cfg_data;
				CFG_FF_ENABLE:  ff_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Error and target change at load
	assign ediff0 = {feature_0[WORD_W-1], feature_0} - {target_0[WORD_W-1], target_0};
	assign ediff1 = {feature_1[WORD_W-1], feature_1} - {target_1[WORD_W-1], target_1};
	assign tdiff0 = {target_0[WORD_W-1], target_0} - {prev0_q[WORD_W-1], prev0_q};
	assign tdiff1 = {target_1[WORD_W-1], target_1} - {prev1_q[WORD_W-1], prev1_q};

	// Advance the previous targets on every transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev0_q <= '0;
			prev1_q <= '0;
			first_q <= 1'b1;
		end else if (cmd.load) begin
			prev0_q <= target_0;
			prev1_q <= target_1;
			first_q <= 1'b0;
		end
	end

	// Capture the item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			j00_q  <= jac_00;
			j01_q  <= jac_01;
			j10_q  <= jac_10;
			j11_q  <= jac_11;
			err0_q <= sat32(SAT_W'(ediff0));
			err1_q <= sat32(SAT_W'(ediff1));
			td0_q  <= first_q ? '0 : tdiff0;
			td1_q  <= first_q ? '0 : tdiff1;
		end
	end

	// Select the operands of the shared multiplier
	always_comb begin
		unique case (cmd.mul_sel)
			MUL_GE0: begin
				mul_a = {2'b00, gain_q};
				mul_b = {err0_q[WORD_W-1], err0_q};
			end
			MUL_GE1: begin
				mul_a = {2'b00, gain_q};
				mul_b = {err1_q[WORD_W-1], err1_q};
			end
			MUL_D0: begin
				mul_a = {j00_q[WORD_W-1], j00_q};
				mul_b = {j11_q[WORD_W-1], j11_q};
			end
			MUL_D1: begin
				mul_a = {j01_q[WORD_W-1], j01_q};
				mul_b = {j10_q[WORD_W-1], j10_q};
			end
			MUL_N00: begin
				mul_a = {j11_q[WORD_W-1], j11_q};
				mul_b = {u0_q[WORD_W-1], u0_q};
			end
			MUL_N01: begin
				mul_a = {j01_q[WORD_W-1], j01_q};
				mul_b = {u1_q[WORD_W-1], u1_q};
			end
			MUL_N10: begin
				mul_a = {j00_q[WORD_W-1], j00_q};
				mul_b = {u1_q[WORD_W-1], u1_q};
			end
			MUL_N11: begin
				mul_a = {j10_q[WORD_W-1], j10_q};
				mul_b = {u0_q[WORD_W-1], u0_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_full = mul_a * mul_b;

	// Register the product
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_s1 <= mul_full[PROD_W-1:0];
		end
	end

	// Round prod / 2^16 half away from zero: bias by 0x7fff below zero, 0x8000 above
	assign rnd_sum = {prod_s1[PROD_W-1], prod_s1}
		+ (prod_s1[PROD_W-1] ? WIDE_W'(16'h7FFF) : WIDE_W'(17'h08000));
	assign rnd_q16 = rnd_sum >>> Q_SHIFT;
	assign td_sel  = !ff_q ? '0 : ((cmd.acc_sel == MUL_GE0) ? td0_q : td1_q);
	assign u_sum   = SAT_W'(td_sel) - SAT_W'(rnd_q16);
	assign diff_acc = hold_q - WIDE_W'(prod_s1);

	// Fold each product into its accumulator
	always_ff @(posedge clk) begin
		if (cmd.acc_en) begin
			unique case (cmd.acc_sel) inside
				MUL_GE0:                  u0_q   <= sat32(u_sum);
				MUL_GE1:                  u1_q   <= sat32(u_sum);
				MUL_D0, MUL_N00, MUL_N10: hold_q <= WIDE_W'(prod_s1);
				MUL_D1:                   det_q  <= diff_acc;
				MUL_N01:                  n0_q   <= diff_acc;
				MUL_N11:                  n1_q   <= diff_acc;
				default: ;
			endcase
		end
	end

	assign det_zero = (det_q == '0);

	ivl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (cmd.div_sel ? n1_q : n0_q),
		.den    (det_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Hold each velocity as its division finishes
	always_ff @(posedge clk) begin
		if (cmd.vel_we) begin
			if (cmd.div_sel) begin
				vel1_q <= div_quo;
			end else begin
				vel0_q <= div_quo;
			end
		end
	end

	// Load the result register; zero velocities when the Jacobian is singular
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_vel0_q <= det_zero ? '0 : vel0_q;
			out_vel1_q <= det_zero ? '0 : vel1_q;
			out_err0_q <= err0_q;
			out_err1_q <= err1_q;
			out_sing_q <= det_zero;
		end
	end

	assign status.div_done = div_done;
	assign status.det_zero = det_zero;

	assign velocity_0 = out_vel0_q;
	assign velocity_1 = out_vel1_q;
	assign error_0    = out_err0_q;
	assign error_1    = out_err1_q;
	assign singular   = out_sing_q;

endmodule

/* hw/rtl/ivl_ctrl.sv */
// Controller of the velocity law: input and output handshakes, multiply
// schedule and divider sequencing. Depends on ivl_pkg.
module ivl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ivl_pkg::ivl_cmd_t    cmd,
	input  ivl_pkg::ivl_status_t status
);
	import ivl_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_DIV0  = 3'd2;
	localparam logic [2:0] ST_WAIT0 = 3'd3;
	localparam logic [2:0] ST_DIV1  = 3'd4;
	localparam logic [2:0] ST_WAIT1 = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic [STEP_W-1:0] step_dec;
	logic              accept;
	logic              out_free;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign step_dec = step_q - STEP_W'(1);

	// Decode commands from the state
	always_comb begin
		cmd      = '0;
		cmd.load = accept;
		unique case (state_q)
			ST_IDLE: ;
			ST_MUL: begin
				cmd.mul_en  = (step_q != STEP_LAST);
				cmd.mul_sel = step_q[MUL_SEL_W-1:0];
				cmd.acc_en  = (step_q != '0);
				cmd.acc_sel = step_dec[MUL_SEL_W-1:0];
			end
			ST_DIV0: begin
				cmd.div_start = 1'b1;
			end
			ST_WAIT0: begin
				cmd.vel_we = status.div_done;
			end
			ST_DIV1: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = 1'b1;
			end
			ST_WAIT1: begin
				cmd.div_sel = 1'b1;
				cmd.vel_we  = status.div_done;
			end
			ST_DONE: begin
				cmd.out_load = out_free;
			end
			default: ;
		endcase
	end

	// Advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MUL;
						step_q  <= '0;
					end
				end
				ST_MUL: begin
					if (step_q == STEP_LAST) begin
						state_q <= status.det_zero ? ST_DONE : ST_DIV0;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_DIV0: state_q <= ST_WAIT0;
				ST_WAIT0: begin
					if (status.div_done) begin
						state_q <= ST_DIV1;
					end
				end
				ST_DIV1: state_q <= ST_WAIT1;
				ST_WAIT1: begin
					if (status.div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

/* hw/rtl/ibvs_velocity_law_2x2.sv */
// Visual servo velocity law, 2 features x 2 actuators, Q16.16.
// One item at a time: the input stays stalled until the result is loaded. Two
// 33-step bit-serial divisions on the shared divider follow the multiply
// schedule; both are skipped when the Jacobian is singular.
// Reset: async active low; gain 1.0, feedforward off, previous targets zero.
`include "ibvs_velocity_law_2x2_defines.svh"

module ibvs_velocity_law_2x2 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ivl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ivl_pkg::GAIN_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  ivl_pkg::word_t                feature_0,
	input  ivl_pkg::word_t                feature_1,
	input  ivl_pkg::word_t                target_0,
	input  ivl_pkg::word_t                target_1,
	input  ivl_pkg::word_t                jac_00,
	input  ivl_pkg::word_t                jac_01,
	input  ivl_pkg::word_t                jac_10,
	input  ivl_pkg::word_t                jac_11,
	output logic                          out_valid,
	input  logic                          out_stall,
	output ivl_pkg::word_t                velocity_0,
	output ivl_pkg::word_t                velocity_1,
	output ivl_pkg::word_t                error_0,
	output ivl_pkg::word_t                error_1,
	output logic                          singular
);
	import ivl_pkg::*;

	ivl_cmd_t    cmd;
	ivl_status_t status;

	ivl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	ivl_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.feature_0  (feature_0),
		.feature_1  (feature_1),
		.target_0   (target_0),
		.target_1   (target_1),
		.jac_00     (jac_00),
		.jac_01     (jac_01),
		.jac_10     (jac_10),
		.jac_11     (jac_11),
		.cmd        (cmd),
		.status     (status),
		.velocity_0 (velocity_0),
		.velocity_1 (velocity_1),
		.error_0    (error_0),
		.error_1    (error_1),
		.singular   (singular)
	);

	// A transaction in makes the block busy on the next cycle
	`IVL_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall)
	// A singular result carries zero velocities
	`IVL_ASSERT_IMPLIES(a_singular_zero, out_valid && singular, velocity_0 == '0 && velocity_1 == '0)
	// Never overwrite a result that is still stalled
	`IVL_ASSERT_IMPLIES(a_load_free, cmd.out_load, !out_valid || !out_stall)

endmodule

/* verif/tb_ibvs_velocity_law_2x2.sv */
// Self-checking testbench for the 2x2 visual servo velocity law block.
// Uses ivl_pkg for port types and register indexes; needs only the RTL.
// Predicts velocity, error and singular flag per transaction and compares in order.
module tb_ibvs_velocity_law_2x2;
	timeunit 1ns;
	timeprecision 1ps;

	import ivl_pkg::*;

	localparam int     ONE         = 65536;
	localparam word_t  W_MAX       = 32'sh7FFF_FFFF;
	localparam word_t  W_MIN       = 32'sh8000_0000;
	localparam longint L_MAX       = 64'sd2147483647;
	localparam longint L_MIN       = -64'sd2147483648;
	localparam int     CYCLE_LIMIT = 1_000_000;
	localparam int     TAIL_CYCLES = 200;

	typedef struct packed {
		word_t f0, f1, t0, t1, j00, j01, j10, j11;
	} servo_tick_t;

	typedef struct packed {
		word_t vel0, vel1, err0, err1;
		logic  sing;
	} velocity_cmd_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [GAIN_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	word_t                feature_0 = '0, feature_1 = '0, target_0 = '0, target_1 = '0;
	word_t                jac_00 = '0, jac_01 = '0, jac_10 = '0, jac_11 = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	word_t                velocity_0, velocity_1, error_0, error_1;
	logic                 singular;

	// Predictor copy of the block's registers and state
	logic [GAIN_W-1:0] gain_model = GAIN_RESET;
	logic              ff_model = 1'b0;
	longint            last_t0 = 0, last_t1 = 0;
	logic              first_model = 1'b1;

	servo_tick_t   tick_queue[$];
	velocity_cmd_t velocity_expected[$];
	servo_tick_t   tick_now;
	word_t         gen_t0 = '0, gen_t1 = '0;
	int unsigned   snd_idle_pct = 0, rcv_idle_pct = 0;
	int            items_queued = 0, results_seen = 0, failures = 0;
	int            cycle_count = 0;

	ibvs_velocity_law_2x2 i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.feature_0(feature_0), .feature_1(feature_1),
		.target_0(target_0), .target_1(target_1),
		.jac_00(jac_00), .jac_01(jac_01), .jac_10(jac_10), .jac_11(jac_11),
		.out_valid(out_valid), .out_stall(out_stall),
		.velocity_0(velocity_0), .velocity_1(velocity_1),
		.error_0(error_0), .error_1(error_1), .singular(singular)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Clamp to the signed 32-bit range
	function automatic longint clamp_word(input longint v);
		if (v > L_MAX) return L_MAX;
		if (v < L_MIN) return L_MIN;
		return v;
	endfunction

	// -(gain * error) / 2^16, rounded half away from zero
	function automatic longint gain_scaled_neg(input logic [GAIN_W-1:0] g, input longint e);
		longint prod, mag;
		prod = longint'({33'd0, g}) * e;
		mag = ((prod < 0) ? -prod : prod) + 64'sd32768;
		mag = mag >>> 16;
		return (prod < 0) ? mag : -mag;
	endfunction

	// Saturated num * 2^16 / den, rounded half away from zero, by restoring steps
	function automatic longint q16_ratio(input logic signed [65:0] num,
			input logic signed [65:0] den);
		logic [65:0] mn, md, q, r, mag;
		logic        neg, bitv;
		int          k;
		mn = num[65] ? -num : num;
		md = den[65] ? -den : den;
		q = mn / md;
		r = mn % md;
		neg = num[65] ^ den[65];
		if (q >= 66'h1_0000) begin
			mag = 66'h1_0000_0000;
		end else begin
			mag = q;
			for (k = 0; k < 16; k++) begin
				bitv = (r >= md - r);
				r = bitv ? r - (md - r) : r + r;
				mag = {mag[64:0], bitv};
			end
			if (r >= md - r) mag = mag + 66'd1;
		end
		if (neg) return (mag > 66'h8000_0000) ? L_MIN : -longint'(mag);
		return (mag > 66'h7FFF_FFFF) ? L_MAX : longint'(mag);
	endfunction

	// Compute one result and advance the target history
	function automatic velocity_cmd_t predict_velocity(input servo_tick_t t);
		velocity_cmd_t    r;
		longint           e0, e1, d0, d1, u0, u1;
		logic signed [65:0] a00, a01, a10, a11, w0, w1, det;
		a00 = $signed(t.j00);
		a01 = $signed(t.j01);
		a10 = $signed(t.j10);
		a11 = $signed(t.j11);
		e0 = clamp_word(longint'($signed(t.f0)) - longint'($signed(t.t0)));
		e1 = clamp_word(longint'($signed(t.f1)) - longint'($signed(t.t1)));
		d0 = first_model ? 0 : longint'($signed(t.t0)) - last_t0;
		d1 = first_model ? 0 : longint'($signed(t.t1)) - last_t1;
		u0 = clamp_word(gain_scaled_neg(gain_model, e0) + (ff_model ? d0 : 0));
		u1 = clamp_word(gain_scaled_neg(gain_model, e1) + (ff_model ? d1 : 0));
		w0 = u0;
		w1 = u1;
		det = a00 * a11 - a01 * a10;
		r.err0 = word_t'(e0);
		r.err1 = word_t'(e1);
		r.sing = (det == 0);
		if (r.sing) begin
			r.vel0 = '0;
			r.vel1 = '0;
		end else begin
			r.vel0 = word_t'(q16_ratio(a11 * w0 - a01 * w1, det));
			r.vel1 = word_t'(q16_ratio(a00 * w1 - a10 * w0, det));
		end
		last_t0 = longint'($signed(t.t0));
		last_t1 = longint'($signed(t.t1));
		first_model = 1'b0;
		return r;
	endfunction

	function automatic word_t near(input int unsigned span);
		return word_t'(int'($urandom_range(0, 2 * span)) - int'(span));
	endfunction

	// Some small values, some extremes, the rest (most often) full range
	function automatic word_t pick_value();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 30) return near(4 * ONE);
		if (sel < 40) begin
			case ($urandom_range(0, 6))
				0: return W_MIN;
				1: return W_MAX;
				2: return '0;
				3: return -32'sd1;
				4: return 32'sd1;
				5: return word_t'(ONE);
				default: return word_t'(-ONE);
			endcase
		end
		return word_t'($urandom);
	endfunction

	function automatic word_t diag_entry();
		int mag;
		mag = int'($urandom_range(ONE / 2, 2 * ONE));
		return word_t'($urandom_range(0, 1) ? mag : -mag);
	endfunction

	// Smooth target trajectory with jumps; Jacobians well-formed, singular or arbitrary
	function automatic servo_tick_t make_tick();
		servo_tick_t t;
		int          k;
		t.t0 = ($urandom_range(0, 9) < 8) ? word_t'(gen_t0 + near(ONE / 4)) : pick_value();
		t.t1 = ($urandom_range(0, 9) < 8) ? word_t'(gen_t1 + near(ONE / 4)) : pick_value();
		gen_t0 = t.t0;
		gen_t1 = t.t1;
		t.f0 = ($urandom_range(0, 3) != 0) ? word_t'(t.t0 + near(2 * ONE)) : pick_value();
		t.f1 = ($urandom_range(0, 3) != 0) ? word_t'(t.t1 + near(2 * ONE)) : pick_value();
		case ($urandom_range(0, 9))
			0: begin
				// second row a multiple of the first
				k = int'($urandom_range(0, 6)) - 3;
				t.j00 = near(2 * ONE);
				t.j01 = near(2 * ONE);
				t.j10 = word_t'(t.j00 * k);
				t.j11 = word_t'(t.j01 * k);
			end
			1: begin
				t.j00 = '0;
				t.j10 = '0;
				t.j01 = pick_value();
				t.j11 = pick_value();
			end
			2, 3, 4, 5: begin
				t.j00 = diag_entry();
				t.j11 = diag_entry();
				t.j01 = near(ONE / 4);
				t.j10 = near(ONE / 4);
			end
			default: begin
				t.j00 = pick_value();
				t.j01 = pick_value();
				t.j10 = pick_value();
				t.j11 = pick_value();
			end
		endcase
		return t;
	endfunction

	function automatic servo_tick_t tick_of(input word_t f0, f1, t0, t1, j00, j01, j10, j11);
		servo_tick_t t;
		t = {f0, f1, t0, t1, j00, j01, j10, j11};
		return t;
	endfunction

	task automatic note_failure(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		failures++;
	endtask

	task automatic check_word(input string name, input word_t got, input word_t want);
		if (got !== want) note_failure($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	task automatic push_tick(input servo_tick_t t);
		tick_queue.insert(tick_queue.size(), t);
		items_queued++;
	endtask

	// Hold off until every queued transaction has produced its result
	task automatic wait_idle();
		while (results_seen != items_queued) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == CFG_SERVO_GAIN) gain_model = data;
		else ff_model = data[0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Feedforward write carries random upper bits, which the block drops
	task automatic set_controls(input logic [GAIN_W-1:0] gain, input logic ff);
		logic [GAIN_W-1:0] ff_word;
		ff_word = GAIN_W'($urandom);
		ff_word[0] = ff;
		write_reg(CFG_SERVO_GAIN, gain);
		write_reg(CFG_FF_ENABLE, ff_word);
	endtask

	task automatic run_phase(input logic [GAIN_W-1:0] gain, input logic ff,
			input int unsigned snd, input int unsigned rcv, input int count);
		set_controls(gain, ff);
		snd_idle_pct = snd;
		rcv_idle_pct = rcv;
		repeat (count) push_tick(make_tick());
		wait_idle();
	endtask

	// Present transactions from the queue; record the prediction on acceptance
	always @(posedge clk) begin : drive_ticks
		logic send;
		if (in_valid && !in_stall) begin
			velocity_expected.insert(velocity_expected.size(), predict_velocity(tick_now));
		end
		if (!in_valid || !in_stall) begin
			send = (tick_queue.size() != 0) && ($urandom_range(0, 99) >= snd_idle_pct);
			if (send) begin
				tick_now = tick_queue.pop_front();
				feature_0 <= tick_now.f0;
				feature_1 <= tick_now.f1;
				target_0 <= tick_now.t0;
				target_1 <= tick_now.t1;
				jac_00 <= tick_now.j00;
				jac_01 <= tick_now.j01;
				jac_10 <= tick_now.j10;
				jac_11 <= tick_now.j11;
			end
			in_valid <= send;
		end
	end

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin : watch_results
		velocity_cmd_t want;
		if (out_valid && !out_stall) begin
			if (velocity_expected.size() == 0) begin
				note_failure("velocity result with no transaction outstanding");
			end else begin
				want = velocity_expected.pop_front();
				check_word("velocity_0", velocity_0, want.vel0);
				check_word("velocity_1", velocity_1, want.vel1);
				check_word("error_0", error_0, want.err0);
				check_word("error_1", error_1, want.err1);
				if (singular !== want.sing)
					note_failure($sformatf("singular got %b want %b", singular, want.sing));
				results_seen++;
			end
		end
		out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
	end

	// Abort a hung run
	always @(posedge clk) begin : watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("ibvs_velocity_law_2x2 regression: fail");
			$finish;
		end
	end

	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		snd_idle_pct = 33;
		rcv_idle_pct = 82;

		// Gain stays at its reset value; feedforward on shows the first-tick rule
		write_reg(CFG_FF_ENABLE, GAIN_W'(1));
		push_tick(tick_of(3 * ONE, -2 * ONE, 5 * ONE, 7 * ONE, ONE, 0, 0, ONE));
		push_tick(tick_of(ONE, ONE, 6 * ONE, 5 * ONE, ONE, 0, 0, ONE));
		push_tick(tick_of(2 * ONE, ONE, 6 * ONE, 5 * ONE, 0, 0, 0, 0));
		push_tick(tick_of(ONE, -ONE, 0, 0, ONE, 2 * ONE, 3 * ONE, 6 * ONE));
		// error saturation both ways, then a full-scale target swing
		push_tick(tick_of(W_MAX, W_MIN, W_MIN, W_MAX, ONE, 0, 0, ONE));
		push_tick(tick_of(W_MAX, W_MIN, W_MAX, W_MIN, ONE, 0, 0, ONE));
		push_tick(tick_of(ONE, ONE, W_MAX, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN));
		push_tick(tick_of(-ONE, 2 * ONE, W_MAX, W_MIN, W_MIN, W_MAX, W_MIN, W_MIN));
		// tiny determinants of both signs, a swap, and half-way velocity rounding
		push_tick(tick_of(ONE, -3 * ONE, 0, 0, 1, 0, 0, 1));
		push_tick(tick_of(-ONE, 5, 0, 0, 1, 0, 0, -1));
		push_tick(tick_of(7 * ONE, 3, 0, 0, 0, ONE, ONE, 0));
		push_tick(tick_of(3, -5, 0, 0, 2 * ONE, 0, 0, 2 * ONE));
		push_tick(tick_of(-7, 9, 0, 0, W_MAX, W_MAX, W_MAX, W_MAX));
		wait_idle();

		// Gain of one LSB: product rounding ties
		set_controls(GAIN_W'(1), 1'b0);
		push_tick(tick_of(32'sh8000, -32'sh8000, 0, 0, ONE, 0, 0, ONE));
		push_tick(tick_of(32'sh7FFF, 32'sh18000, 0, 0, ONE, 0, 0, ONE));
		push_tick(tick_of(-32'sh18000, 32'sh28000, 0, 0, ONE, ONE / 2, 0, ONE));
		wait_idle();

		// Largest gain, then zero gain
		set_controls({GAIN_W{1'b1}}, 1'b1);
		push_tick(tick_of(W_MAX, W_MIN, W_MIN, W_MAX, ONE, 0, 0, ONE));
		push_tick(tick_of(-3, 2, 1, 1, ONE, ONE / 4, -ONE / 4, ONE));
		wait_idle();
		set_controls(GAIN_W'(0), 1'b0);
		push_tick(tick_of(5 * ONE, -5 * ONE, 0, ONE, ONE, 0, 0, ONE));
		push_tick(tick_of(W_MIN, W_MAX, ONE, 0, 2 * ONE, ONE, ONE, 3 * ONE));
		wait_idle();

		// Random phases: slow receiver, then slow sender, then no idling
		run_phase(GAIN_RESET, 1'b1, 33, 82, 300);
		run_phase(GAIN_W'($urandom_range(0, 32'h4_0000)), 1'b1, 33, 82, 250);
		run_phase({GAIN_W{1'b1}}, 1'b0, 82, 33, 250);
		run_phase(GAIN_W'($urandom), 1'b1, 82, 33, 250);
		run_phase(GAIN_W'(0), 1'b1, 0, 0, 150);
		run_phase(GAIN_W'($urandom_range(0, 32'h4_0000)), 1'b0, 0, 0, 250);
		run_phase(GAIN_W'(1), 1'($urandom_range(0, 1)), 0, 0, 250);

		// Watch for stray results after the last one
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("ibvs_velocity_law_2x2 regression: pass");
		end else begin
			$display("ibvs_velocity_law_2x2 regression: fail");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/ivl_pkg.sv
hw/rtl/ivl_div.sv
hw/rtl/ivl_datapath.sv
hw/rtl/ivl_ctrl.sv
hw/rtl/ibvs_velocity_law_2x2.sv
verif/tb_ibvs_velocity_law_2x2.sv
